// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Next-cycle implication built on the clocked form.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons))

`endif

// ----- rtl/tgfs_pkg.sv -----
// Types, constants, glyph ROM and palette for the glyph frame buffer.
`default_nettype none
package tgfs_pkg;

   localparam int FRAME_WIDTH_DEF  = 160;
   localparam int FRAME_HEIGHT_DEF = 128;
   localparam int NUM_BANKS        = 8;
   localparam int GLYPH_COLS       = 6;
   localparam int LINE_STEP        = 10;

   localparam logic [1:0] OP_PLACE = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_SCAN  = 2'd2;

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3f;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [3:0] color;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [NUM_BANKS-1:0] we;
      logic [NUM_BANKS-1:0] inc;
      logic [3:0]           wdata;
      logic                 rd_en;
   } bank_ctrl_type;

   function automatic logic [8:0] sat_add9(input logic [8:0] a, input logic [3:0] b);
      logic [9:0] s;
      s = {1'b0, a} + 10'(b);
      return s[9] ? 9'h1ff : s[8:0];
   endfunction

   // Column 0 in the top byte, bit 0 of a column is the top row.
   function automatic logic [47:0] glyph_bits(input logic [6:0] idx);
      logic [47:0] g;
      case (idx)
         7'd0:  g = 48'h000000000000;
         7'd1:  g = 48'h00005e000000;
         7'd2:  g = 48'h000e000e0000;
         7'd3:  g = 48'h28fe28fe2800;
         7'd4:  g = 48'h4c92ff926400;
         7'd5:  g = 48'h02651248a640;
         7'd6:  g = 48'h6c92926ca000;
         7'd7:  g = 48'h00000e000000;
         7'd8:  g = 48'h00007c820000;
         7'd9:  g = 48'h0000827c0000;
         7'd10: g = 48'h543810385400;
         7'd11: g = 48'h10107c101000;
         7'd12: g = 48'h000090700000;
         7'd13: g = 48'h101010101000;
         7'd14: g = 48'h000060600000;
         7'd15: g = 48'h006010080600;
         7'd16: g = 48'h003c42423c00;
         7'd17: g = 48'h00447e400000;
         7'd18: g = 48'h004462524c00;
         7'd19: g = 48'h00424a4e3200;
         7'd20: g = 48'h3028247e2000;
         7'd21: g = 48'h004e4a4a3200;
         7'd22: g = 48'h003c4a4a3000;
         7'd23: g = 48'h000262120e00;
         7'd24: g = 48'h00344a4a3400;
         7'd25: g = 48'h000c52523c00;
         7'd26: g = 48'h00006c6c0000;
         7'd27: g = 48'h000096760000;
         7'd28: g = 48'h102828444400;
         7'd29: g = 48'h282828282800;
         7'd30: g = 48'h444428281000;
         7'd31: g = 48'h000259090600;
         7'd32: g = 48'h3c425a560800;
         7'd33: g = 48'h781412147800;
         7'd34: g = 48'h7e4a4a4a3400;
         7'd35: g = 48'h003c42422400;
         7'd36: g = 48'h007e42423c00;
         7'd37: g = 48'h007e4a4a4200;
         7'd38: g = 48'h007e0a0a0200;
         7'd39: g = 48'h003c42523400;
         7'd40: g = 48'h007e08087e00;
         7'd41: g = 48'h00427e420000;
         7'd42: g = 48'h2040423e0200;
         7'd43: g = 48'h007e08146200;
         7'd44: g = 48'h007e40404000;
         7'd45: g = 48'h7e0418047e00;
         7'd46: g = 48'h007e04087e00;
         7'd47: g = 48'h3c4242423c00;
         7'd48: g = 48'h007e12120c00;
         7'd49: g = 48'h003c5262bc00;
         7'd50: g = 48'h007e12126c00;
         7'd51: g = 48'h00244a522400;
         7'd52: g = 48'h02027e020200;
         7'd53: g = 48'h003e40403e00;
         7'd54: g = 48'h001e70701e00;
         7'd55: g = 48'h7e2018207e00;
         7'd56: g = 48'h422418244200;
         7'd57: g = 48'h060870080600;
         7'd58: g = 48'h0062524a4600;
         7'd59: g = 48'h007e42420000;
         7'd60: g = 48'h000608106000;
         7'd61: g = 48'h0042427e0000;
         7'd62: g = 48'h080402040800;
         7'd63: g = 48'h808080808000;
         7'd64: g = 48'h000002040000;
         7'd65: g = 48'h003048487800;
         7'd66: g = 48'h007e48483000;
         7'd67: g = 48'h003048484800;
         7'd68: g = 48'h003048487e00;
         7'd69: g = 48'h003068585000;
         7'd70: g = 48'h00107c120400;
         7'd71: g = 48'h0018a4a47800;
         7'd72: g = 48'h007e08087000;
         7'd73: g = 48'h00487a400000;
         7'd74: g = 48'h0040847d0000;
         7'd75: g = 48'h007e10284000;
         7'd76: g = 48'h00427e400000;
         7'd77: g = 48'h780830087000;
         7'd78: g = 48'h007808087000;
         7'd79: g = 48'h003048483000;
         7'd80: g = 48'h00fc24241800;
         7'd81: g = 48'h00182424fc00;
         7'd82: g = 48'h007810081000;
         7'd83: g = 48'h005058682800;
         7'd84: g = 48'h00083e482000;
         7'd85: g = 48'h003840407800;
         7'd86: g = 48'h001860601800;
         7'd87: g = 48'h384030403800;
         7'd88: g = 48'h004830304800;
         7'd89: g = 48'h005ca0a07c00;
         7'd90: g = 48'h004868584800;
         7'd91: g = 48'h000836410000;
         7'd92: g = 48'h0000fe000000;
         7'd93: g = 48'h004136080000;
         7'd94: g = 48'h000804080400;
         default: g = 48'h000000000000;
      endcase
      return g;
   endfunction

   function automatic logic [15:0] palette_rgb(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:  c = 16'h0000;
         4'd1:  c = 16'hFFFF;
         4'd2:  c = 16'hF904;
         4'd3:  c = 16'hFC98;
         4'd4:  c = 16'hFC06;
         4'd5:  c = 16'hFFA1;
         4'd6:  c = 16'h24F4;
         4'd7:  c = 16'h7EEA;
         4'd8:  c = 16'h01F5;
         4'd9:  c = 16'h879F;
         4'd10: c = 16'h8978;
         4'd11: c = 16'hA413;
         4'd12: c = 16'h5A0D;
         4'd13: c = 16'hE678;
         4'd14: c = 16'h9227;
         default: c = 16'h0000;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/tgfs_addr_unit.sv -----
// Shared address unit: column times bank height plus row group.
`default_nettype none
module tgfs_addr_unit #(
   parameter int FRAME_WIDTH  = tgfs_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tgfs_pkg::FRAME_HEIGHT_DEF,
   localparam int HB    = (FRAME_HEIGHT + tgfs_pkg::NUM_BANKS - 1) / tgfs_pkg::NUM_BANKS,
   localparam int DEPTH = FRAME_WIDTH * HB,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic [7:0]    col,
   input  logic [7:0]    row,
   output logic [AW-1:0] addr
);
   import tgfs_pkg::*;

   logic [15:0] prod;

   assign prod = 16'(col) * 16'(HB);
   assign addr = AW'(prod + 16'(row[7:3]));

endmodule
`default_nettype wire

// ----- rtl/tgfs_frame_banks.sv -----
// Frame store as eight row-interleaved banks of palette indices.
`default_nettype none
module tgfs_frame_banks #(
   parameter int FRAME_WIDTH  = tgfs_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tgfs_pkg::FRAME_HEIGHT_DEF,
   localparam int HB    = (FRAME_HEIGHT + tgfs_pkg::NUM_BANKS - 1) / tgfs_pkg::NUM_BANKS,
   localparam int DEPTH = FRAME_WIDTH * HB,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  tgfs_pkg::bank_ctrl_type                ctrl,
   input  logic [AW-1:0]                          addr,
   output logic [tgfs_pkg::NUM_BANKS-1:0][3:0]    rdata
);
   import tgfs_pkg::*;

   logic [NUM_BANKS-1:0][3:0] rdata_ff;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [3:0]    mem [DEPTH];
      logic [AW-1:0] waddr;

      assign waddr = addr + AW'(ctrl.inc[b]);

      always_ff @(posedge clock) begin
         if (ctrl.we[b]) begin
            mem[waddr] <= ctrl.wdata;
         end
         if (ctrl.rd_en) begin
            rdata_ff[b] <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/text_glyph_framebuffer_scanout.sv -----
// Place cursor, carriage return, line feed: done in the cycle that accepts the request.
// Character: one glyph column per cycle in the draw state, through the shared address unit
// into eight row-interleaved banks.
// Scan: read state, then data state, which registers the result once any held response is taken, then idle.
// Reset: clears the frame, one bank row per cycle, no request accepted meanwhile.
`default_nettype none
`include "assert_macros.svh"
module text_glyph_framebuffer_scanout #(
   parameter int FRAME_WIDTH  = tgfs_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tgfs_pkg::FRAME_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tgfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tgfs_pkg::rsp_type rsp_data
);
   import tgfs_pkg::*;

   localparam int HB    = (FRAME_HEIGHT + NUM_BANKS - 1) / NUM_BANKS;
   localparam int DEPTH = FRAME_WIDTH * HB;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DRAW  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_DATA  = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic [8:0]    cursor_col_ff, cursor_col_in;
   logic [8:0]    cursor_row_ff, cursor_row_in;
   logic [7:0]    origin_ff, origin_in;
   logic [3:0]    color_ff, color_in;
   logic [7:0]    scan_col_ff, scan_col_in;
   logic [7:0]    scan_row_ff, scan_row_in;
   logic [2:0]    col_cnt_ff, col_cnt_in;
   logic [47:0]   glyph_ff, glyph_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic                      accept;
   logic                      load_rsp;
   logic                      scan_last;
   logic [7:0]                code_sel;
   logic [9:0]                draw_col;
   logic [7:0]                col_bits;
   logic [7:0]                unit_col;
   logic [7:0]                unit_row;
   logic [AW-1:0]             unit_addr;
   logic [AW-1:0]             bank_addr;
   logic [NUM_BANKS-1:0][3:0] bank_rdata;
   bank_ctrl_type             bank_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign draw_col  = {1'b0, cursor_col_ff} + 10'(col_cnt_ff);
   assign col_bits  = glyph_ff[47:40];
   assign scan_last = (scan_col_ff == 8'(FRAME_WIDTH - 1)) &&
                      (scan_row_ff == 8'(FRAME_HEIGHT - 1));
   assign load_rsp  = (state_ff == ST_DATA) && (!rsp_valid_ff || rsp_ready);

   assign code_sel = (req_data.char_code < CHAR_SPACE || req_data.char_code >= CHAR_DEL)
                     ? CHAR_QMARK : req_data.char_code;

   assign unit_col  = (state_ff == ST_DRAW) ? draw_col[7:0] : scan_col_ff;
   assign unit_row  = (state_ff == ST_DRAW) ? cursor_row_ff[7:0] : scan_row_ff;
   assign bank_addr = (state_ff == ST_CLEAR) ? clear_cnt_ff : unit_addr;

   tgfs_addr_unit #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_addr (
      .col  (unit_col),
      .row  (unit_row),
      .addr (unit_addr)
   );

   tgfs_frame_banks #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_banks (
      .clock (clock),
      .ctrl  (bank_ctrl),
      .addr  (bank_addr),
      .rdata (bank_rdata)
   );

   // bank b takes glyph row j = b - cursor_row mod 8
   always_comb begin
      logic [2:0] j;
      logic [9:0] row_j;
      j               = '0;
      row_j           = '0;
      bank_ctrl       = '0;
      bank_ctrl.wdata = color_ff;
      bank_ctrl.rd_en = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         bank_ctrl.we    = '1;
         bank_ctrl.wdata = 4'd0;
      end else if (state_ff == ST_DRAW) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            j     = 3'(b) - cursor_row_ff[2:0];
            row_j = {1'b0, cursor_row_ff} + 10'(j);
            bank_ctrl.inc[b] = (3'(b) < cursor_row_ff[2:0]);
            bank_ctrl.we[b]  = col_bits[j] && (row_j < 10'(FRAME_HEIGHT)) &&
                               (draw_col < 10'(FRAME_WIDTH));
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      origin_in     = origin_ff;
      color_in      = color_ff;
      scan_col_in   = scan_col_ff;
      scan_row_in   = scan_row_ff;
      col_cnt_in    = col_cnt_ff;
      glyph_in      = glyph_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_PLACE: begin
                     cursor_col_in = {1'b0, req_data.x_pos};
                     origin_in     = req_data.x_pos;
                     cursor_row_in = {1'b0, req_data.y_pos};
                     color_in      = req_data.color;
                  end
                  OP_CHAR: begin
                     if (req_data.char_code == CHAR_LF) begin
                        cursor_col_in = {1'b0, origin_ff};
                        cursor_row_in = sat_add9(cursor_row_ff, 4'(LINE_STEP));
                     end else if (req_data.char_code != CHAR_CR) begin
                        glyph_in   = glyph_bits(7'(code_sel - CHAR_SPACE));
                        col_cnt_in = 3'd0;
                        state_in   = ST_DRAW;
                     end
                  end
                  OP_SCAN: state_in = ST_READ;
                  default: ;
               endcase
            end
         end
         ST_DRAW: begin
            glyph_in   = {glyph_ff[39:0], 8'h00};
            col_cnt_in = col_cnt_ff + 3'd1;
            if (col_cnt_ff == LAST_COL) begin
               cursor_col_in = sat_add9(cursor_col_ff, 4'(GLYPH_COLS));
               state_in      = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_DATA;
         ST_DATA: begin
            if (load_rsp) begin
               rsp_in.pixel_rgb565 = palette_rgb(bank_rdata[scan_row_ff[2:0]]);
               rsp_in.last_pixel   = scan_last;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
               if (scan_row_ff == 8'(FRAME_HEIGHT - 1)) begin
                  scan_row_in = 8'd0;
                  scan_col_in = scan_last ? 8'd0 : scan_col_ff + 8'd1;
               end else begin
                  scan_row_in = scan_row_ff + 8'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_cnt_ff  <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         origin_ff     <= '0;
         color_ff      <= '0;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         col_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         origin_ff     <= origin_in;
         color_ff      <= color_in;
         scan_col_ff   <= scan_col_in;
         scan_row_ff   <= scan_row_in;
         col_cnt_ff    <= col_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      glyph_ff <= glyph_in;
      rsp_ff   <= rsp_in;
   end

   `ASSERT_NEXT(a_draw_done, clock, reset, (state_ff == ST_DRAW && col_cnt_ff == LAST_COL), (state_ff == ST_IDLE))
   `ASSERT_CLK(a_no_write_scan, clock, reset, (state_ff == ST_READ || state_ff == ST_DATA) |-> (bank_ctrl.we == '0))
   `ASSERT_CLK(a_rsp_from_data, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DATA))
   `ASSERT_NEXT(a_scan_wrap, clock, reset, (load_rsp && scan_last), (scan_col_ff == 8'd0 && scan_row_ff == 8'd0))

endmodule
`default_nettype wire
